[hw/rtl/kpt_pkg.sv]
// ----------------------------------------------------------------------------
// kpt_pkg
// Shared codes and types of the keyed priority table: operation and status
// codes, the no-match priority and the scan status bundle.
// ----------------------------------------------------------------------------
package kpt_pkg;

  typedef logic [1:0]  op_t;
  typedef logic [1:0]  status_t;
  typedef logic [31:0] word_t;

  // operation codes
  localparam op_t OP_APPEND = 2'd0;
  localparam op_t OP_LOOKUP = 2'd1;
  localparam op_t OP_CHANGE = 2'd2;
  localparam op_t OP_NOP    = 2'd3;

  // status codes
  localparam status_t ST_DONE      = 2'd0;
  localparam status_t ST_FOUND     = 2'd1;
  localparam status_t ST_NOT_FOUND = 2'd2;
  localparam status_t ST_FULL      = 2'd3;

  // priority returned by a lookup without a match
  localparam word_t PRIO_NONE = 32'hFFFF_FFFF;
  localparam word_t PRIO_ZERO = 32'h0000_0000;

  // scan result, one cycle pulse each
  typedef struct packed {
    logic hit;
    logic miss;
  } scan_sts_t;

endpackage

[hw/rtl/kpt_in_if.sv]
// ----------------------------------------------------------------------------
// kpt_in_if
// Request channel of the keyed priority table: valid/ready plus one operation.
// ----------------------------------------------------------------------------
interface kpt_in_if;
  import kpt_pkg::*;

  logic  valid;
  logic  ready;
  op_t   operation;
  word_t key;
  word_t new_priority;

  modport source (output valid, output operation, output key, output new_priority,
                  input ready);
  modport sink (input valid, input operation, input key, input new_priority,
                output ready);
endinterface

[hw/rtl/kpt_out_if.sv]
// ----------------------------------------------------------------------------
// kpt_out_if
// Result channel of the keyed priority table: valid/ready plus one status item.
// ----------------------------------------------------------------------------
interface kpt_out_if;
  import kpt_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;
  word_t   key_echo;
  word_t   priority_out;

  modport source (output valid, output status, output key_echo, output priority_out,
                  input ready);
  modport sink (input valid, input status, input key_echo, input priority_out,
                output ready);
endinterface

[hw/rtl/kpt_ram.sv]
// ----------------------------------------------------------------------------
// kpt_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module kpt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/kpt_scan.sv]
// ----------------------------------------------------------------------------
// kpt_scan
// Newest-first key scan: walks the key RAM one address per cycle from the
// newest entry down and compares each read word with the search key in one
// shared comparator; reports the first hit or a miss after the oldest entry.
// ----------------------------------------------------------------------------
module kpt_scan
  import kpt_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         start,
  input  logic [$clog2(CAPACITY+1)-1:0]                count,
  input  word_t                                        key_q,
  input  word_t                                        key_rdata,
  output logic                                         rd_en,
  output logic [(CAPACITY > 1 ? $clog2(CAPACITY) : 1)-1:0] rd_addr,
  output scan_sts_t                                    sts,
  output logic [(CAPACITY > 1 ? $clog2(CAPACITY) : 1)-1:0] hit_idx
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic          active_r;
  logic [AW-1:0] idx_r;
  logic [CW-1:0] left_r;
  logic          pend_r;
  logic [AW-1:0] pend_idx_r;
  logic          issue;
  logic          match;
  logic          exhausted;

  // one read issued per cycle while entries remain
  assign issue   = active_r && (left_r != '0);
  assign rd_en   = issue;
  assign rd_addr = idx_r;

  // shared comparator on the word read in the previous cycle
  assign match     = active_r && pend_r && (key_rdata == key_q);
  assign exhausted = active_r && !pend_r && (left_r == '0);

  assign sts.hit  = match;
  assign sts.miss = exhausted;
  assign hit_idx  = pend_idx_r;

  // scan control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      pend_r   <= 1'b0;
    end else if (start) begin
      active_r <= 1'b1;
      pend_r   <= 1'b0;
    end else if (active_r) begin
      if (match || exhausted) begin
        active_r <= 1'b0;
      end
      pend_r <= issue;
    end
  end

  // address walk
  always_ff @(posedge clk) begin
    if (start) begin
      idx_r  <= AW'(count - CW'(1));
      left_r <= count;
    end else if (issue) begin
      idx_r      <= idx_r - AW'(1);
      left_r     <= left_r - CW'(1);
      pend_idx_r <= idx_r;
    end
  end

endmodule

[hw/rtl/keyed_priority_table.sv]
// ----------------------------------------------------------------------------
// keyed_priority_table
// Bounded table of (key, priority) entries in insertion order with append,
// newest-match lookup and newest-match priority change.
// ----------------------------------------------------------------------------
// Usage:
//   in_if  : one operation per transfer (operation, key, new_priority).
//   out_if : exactly one result per operation (status, key_echo, priority_out).
//   The block works on one operation at a time; in_if.ready is high only
//   while the sequencer is idle, so with a free output register the next
//   transfer can follow in the cycle the previous result turns valid.
//   From S_IDLE the sequencer steps through these states, comparing the
//   entries newest first in S_SCAN, and then loads the output register:
//     append / no-op          : S_RESP
//     change with a match     : S_SCAN, S_RESP
//     lookup with a match     : S_SCAN, S_FETCH, S_RESP
//     lookup or change miss   : S_SCAN, S_RESP, also on an empty table
//   The key RAM is read one address per cycle through a single comparator,
//   which sets the scan length.
//   The result sits in an output register; a finished result waiting on a
//   stalled receiver does not block the next input transfer, but the
//   sequencer holds a further result until the output register frees up.
//   Reset (rst_n low, synchronous) empties the table (entry count zero) and
//   clears both channels; RAM contents are not cleared and need no pass.
// ----------------------------------------------------------------------------
module keyed_priority_table
  import kpt_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  kpt_in_if.sink   in_if,
  kpt_out_if.source out_if
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_FETCH = 2'd2;
  localparam logic [1:0] S_RESP  = 2'd3;

  logic [1:0]    state_r;
  logic [1:0]    state_nxt;
  logic [CW-1:0] count_r;
  op_t           op_r;
  word_t         key_r;
  word_t         prio_r;
  status_t       res_status_r;
  word_t         res_prio_r;
  logic          out_valid_r;
  status_t       out_status_r;
  word_t         out_key_r;
  word_t         out_prio_r;

  logic          in_xfer;
  logic          append_ok;
  logic          scan_start;
  logic          out_free;

  logic          key_we;
  logic          key_re;
  logic [AW-1:0] key_raddr;
  word_t         key_rdata;
  logic          prio_we;
  logic [AW-1:0] prio_waddr;
  word_t         prio_wdata;
  logic          prio_re;
  word_t         prio_rdata;
  scan_sts_t     scan_sts;
  logic [AW-1:0] hit_idx;

  assign in_if.ready = (state_r == S_IDLE);
  assign in_xfer     = in_if.valid && in_if.ready;
  assign append_ok   = (count_r < CW'(CAPACITY));
  assign scan_start  = in_xfer &&
                       ((in_if.operation == OP_LOOKUP) || (in_if.operation == OP_CHANGE));
  assign out_free    = !out_valid_r || out_if.ready;

  // table storage
  assign key_we = in_xfer && (in_if.operation == OP_APPEND) && append_ok;

  kpt_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (count_r[AW-1:0]),
    .wdata (in_if.key),
    .re    (key_re),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  // priority write: append at transfer, change on a hit
  always_comb begin
    prio_we    = 1'b0;
    prio_waddr = count_r[AW-1:0];
    prio_wdata = in_if.new_priority;
    if (key_we) begin
      prio_we = 1'b1;
    end else if ((state_r == S_SCAN) && scan_sts.hit && (op_r == OP_CHANGE)) begin
      prio_we    = 1'b1;
      prio_waddr = hit_idx;
      prio_wdata = prio_r;
    end
  end

  assign prio_re = (state_r == S_SCAN) && scan_sts.hit && (op_r == OP_LOOKUP);

  kpt_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_prio_ram (
    .clk   (clk),
    .we    (prio_we),
    .waddr (prio_waddr),
    .wdata (prio_wdata),
    .re    (prio_re),
    .raddr (hit_idx),
    .rdata (prio_rdata)
  );

  // key scan unit, compares against the captured request key
  kpt_scan #(.CAPACITY(CAPACITY)) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (scan_start),
    .count     (count_r),
    .key_q     (key_r),
    .key_rdata (key_rdata),
    .rd_en     (key_re),
    .rd_addr   (key_raddr),
    .sts       (scan_sts),
    .hit_idx   (hit_idx)
  );

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (scan_start) begin
          state_nxt = S_SCAN;
        end else if (in_xfer) begin
          state_nxt = S_RESP;
        end
      end
      S_SCAN: begin
        if (scan_sts.hit && (op_r == OP_LOOKUP)) begin
          state_nxt = S_FETCH;
        end else if (scan_sts.hit || scan_sts.miss) begin
          state_nxt = S_RESP;
        end
      end
      S_FETCH: state_nxt = S_RESP;
      S_RESP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (key_we) begin
        count_r <= count_r + CW'(1);
      end
    end
  end

  // request capture and result formation
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          op_r       <= in_if.operation;
          key_r      <= in_if.key;
          prio_r     <= in_if.new_priority;
          res_prio_r <= PRIO_ZERO;
          if ((in_if.operation == OP_APPEND) && !append_ok) begin
            res_status_r <= ST_FULL;
          end else begin
            res_status_r <= ST_DONE;
          end
        end
      end
      S_SCAN: begin
        if (scan_sts.hit) begin
          res_status_r <= ST_FOUND;
        end else if (scan_sts.miss) begin
          res_status_r <= ST_NOT_FOUND;
          res_prio_r   <= (op_r == OP_LOOKUP) ? PRIO_NONE : PRIO_ZERO;
        end
      end
      S_FETCH: res_prio_r <= prio_rdata;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_RESP) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_RESP) && out_free) begin
      out_status_r <= res_status_r;
      out_key_r    <= key_r;
      out_prio_r   <= res_prio_r;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.status       = out_status_r;
  assign out_if.key_echo     = out_key_r;
  assign out_if.priority_out = out_prio_r;

endmodule

[hw/rtl/kpt_checker.sv]
// ----------------------------------------------------------------------------
// kpt_checker
// Port-level checks of the keyed priority table, bound to the top level.
// ----------------------------------------------------------------------------
module kpt_checker
  import kpt_pkg::*;
(
  input logic    clk,
  input logic    rst_n,
  input logic    in_valid,
  input logic    in_ready,
  input logic    out_valid,
  input logic    out_ready,
  input status_t out_status,
  input word_t   out_priority
);

  // one operation at a time: ready drops after each input transfer
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an operation is in progress");

  // a stalled result stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // append and no-op results carry a zero priority
  a_zero_prio: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_status == ST_DONE) || (out_status == ST_FULL))
      |-> (out_priority == PRIO_ZERO))
    else $error("nonzero priority on a done or full result");

  // reset empties the result channel
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind keyed_priority_table kpt_checker u_kpt_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_if.valid),
  .in_ready     (in_if.ready),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .out_status   (out_if.status),
  .out_priority (out_if.priority_out)
);
